FILE: rtl/pmct_pkg.sv
`timescale 1ns / 1ps

package pmct_pkg;

    // Cursor coordinate storage width and the hard upper bound on a position.
    localparam int COORD_W    = 12;
    localparam int COORD_BITS = 12;
    localparam logic [COORD_W-1:0] COORD_CAP = COORD_W'((2 ** COORD_BITS) - 1);

    // Button mask and event counter widths.
    localparam int BTN_W   = 32;
    localparam int COUNT_W = 32;

    // Reset values of the configuration registers.
    localparam logic [COORD_W-1:0] MAX_X_RST   = COORD_W'(639);
    localparam logic [COORD_W-1:0] MAX_Y_RST   = COORD_W'(479);
    localparam logic [COORD_W-1:0] SPLIT_X_RST = COORD_W'(320);
    localparam logic [COORD_W-1:0] SPLIT_Y_RST = COORD_W'(250);

    // Reset position of the cursor.
    localparam logic [COORD_W-1:0] POS_X_RST = COORD_W'(32);
    localparam logic [COORD_W-1:0] POS_Y_RST = COORD_W'(24);

    // A packet's first byte carries the three standard buttons.
    localparam logic [7:0] PKT_BTN_MASK = 8'h07;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MAX_X   = 2'd0,
        CFG_MAX_Y   = 2'd1,
        CFG_SPLIT_X = 2'd2,
        CFG_SPLIT_Y = 2'd3
    } t_cfg_reg;

    // Input command codes.
    typedef enum logic [1:0] {
        ACT_BYTE   = 2'd0,
        ACT_MOVE   = 2'd1,
        ACT_SET    = 2'd2,
        ACT_BUTTON = 2'd3
    } t_action;

    // Event codes reported with each result.
    typedef enum logic [2:0] {
        KIND_PACKET = 3'd0,
        KIND_MOVE   = 3'd1,
        KIND_SET    = 3'd2,
        KIND_DOWN   = 3'd3,
        KIND_UP     = 3'd4
    } t_event_kind;

    typedef struct packed {
        t_action            action;
        logic [7:0]         data_byte;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic [4:0]         button_index;
        logic               button_down;
    } t_in_word;

    typedef struct packed {
        t_event_kind        event_kind;
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic [BTN_W-1:0]   button_mask;
        logic               focus_request;
        logic [1:0]         focus_region;
        logic [COUNT_W-1:0] event_total;
    } t_out_word;

    typedef struct packed {
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
        logic [COORD_W-1:0] split_x;
        logic [COORD_W-1:0] split_y;
    } t_cfg;

    // Tracker state that reset clears.
    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [BTN_W-1:0]   buttons;
        logic [COUNT_W-1:0] event_count;
        logic [1:0]         byte_index;
    } t_track_state;

    // Clamp a signed candidate position to zero and to the smaller of the
    // register limit and the coordinate cap.
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [17:0]  value,
        input logic [COORD_W-1:0]  lim_reg
    );
        logic [COORD_W-1:0] lim;
        lim = (lim_reg < COORD_CAP) ? lim_reg : COORD_CAP;
        if (value < 0) begin
            clamp_coord = '0;
        end else if (value > $signed({6'd0, lim})) begin
            clamp_coord = lim;
        end else begin
            clamp_coord = value[COORD_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/ps2_mouse_cursor_tracker_unit.sv
`timescale 1ns / 1ps

// A result word is registered into the output register after its input word is taken, or into the
// skid stage while an unaccepted output word is held there; bytes 0 and 1 give none.
// Throughput: one input word per cycle while input ready is high; a single add-and-clamp stage.
// The output register plus a one-word skid stage keep input ready high unless both are full.
// Reset (synchronous, active low) sets the cursor to (32, 24), clears buttons and event count,
// and loads the default limits and splits; the two stored packet bytes are not reset.
module ps2_mouse_cursor_tracker_unit
    import pmct_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_word        i_in_word,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_word       o_out_word,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [COORD_W-1:0] i_cfg_wdata
);

    t_cfg         r_cfg;
    t_track_state r_state;
    t_track_state n_state;
    logic [7:0]   r_pkt [2];

    logic         pkt_we;
    logic         step_valid;
    t_out_word    step_word;

    logic         in_take;
    logic         res_push;
    logic         out_pop;

    logic         r_out_valid;
    logic         n_out_valid;
    logic         r_skid_valid;
    logic         n_skid_valid;
    t_out_word    r_out_word;
    t_out_word    n_out_word;
    t_out_word    r_skid_word;
    t_out_word    n_skid_word;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_x   <= MAX_X_RST;
            r_cfg.max_y   <= MAX_Y_RST;
            r_cfg.split_x <= SPLIT_X_RST;
            r_cfg.split_y <= SPLIT_Y_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MAX_X:   r_cfg.max_x   <= i_cfg_wdata;
                CFG_MAX_Y:   r_cfg.max_y   <= i_cfg_wdata;
                CFG_SPLIT_X: r_cfg.split_x <= i_cfg_wdata;
                CFG_SPLIT_Y: r_cfg.split_y <= i_cfg_wdata;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    pmct_step u_step (
        .i_state        (r_state),
        .i_pkt0         (r_pkt[0]),
        .i_pkt1         (r_pkt[1]),
        .i_cfg          (r_cfg),
        .i_word         (i_in_word),
        .o_state        (n_state),
        .o_pkt_we       (pkt_we),
        .o_result_valid (step_valid),
        .o_result       (step_word)
    );

    assign o_in_ready = !r_skid_valid;
    assign in_take    = i_in_valid && o_in_ready;
    assign res_push   = in_take && step_valid;
    assign out_pop    = r_out_valid && i_out_ready;

    // Tracker state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pos_x       <= POS_X_RST;
            r_state.pos_y       <= POS_Y_RST;
            r_state.buttons     <= '0;
            r_state.event_count <= '0;
            r_state.byte_index  <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // Partial packet bytes.
    always_ff @(posedge i_clk) begin
        if (in_take && pkt_we) begin
            r_pkt[r_state.byte_index[0]] <= i_in_word.data_byte;
        end
    end

    // Output register and skid stage steering.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_word   = r_out_word;
        n_skid_word  = r_skid_word;
        if (r_skid_valid) begin
            if (out_pop) begin
                n_out_word   = r_skid_word;
                n_skid_valid = 1'b0;
            end
        end else if (res_push) begin
            if (!r_out_valid || out_pop) begin
                n_out_word  = step_word;
                n_out_valid = 1'b1;
            end else begin
                n_skid_word  = step_word;
                n_skid_valid = 1'b1;
            end
        end else if (out_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word  <= n_out_word;
        r_skid_word <= n_skid_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // The skid stage only fills behind a held output word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held while output register empty");

    // Every result advances the event count by one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |=> r_state.event_count == $past(r_state.event_count) + COUNT_W'(1))
        else $error("event count did not advance with a result");

    // Without a result the event count holds.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !res_push |=> $stable(r_state.event_count))
        else $error("event count changed without a result");

    // The packet byte position never passes the third byte.
    a_byte_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.byte_index != 2'd3)
        else $error("packet byte index out of range");

    // A region is only reported alongside a focus request.
    a_region_needs_focus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.focus_request) |-> o_out_word.focus_region == 2'd0)
        else $error("focus region set without focus request");
`endif

endmodule

FILE: rtl/pmct_step.sv
`timescale 1ns / 1ps

module pmct_step
    import pmct_pkg::*;
(
    input  t_track_state i_state,
    input  logic [7:0]   i_pkt0,
    input  logic [7:0]   i_pkt1,
    input  t_cfg         i_cfg,
    input  t_in_word     i_word,
    output t_track_state o_state,
    output logic         o_pkt_we,
    output logic         o_result_valid,
    output t_out_word    o_result
);

    localparam logic [1:0] PKT_LAST = 2'd2;

    logic signed [17:0] cand_x;
    logic signed [17:0] cand_y;
    logic               upd_pos;
    logic               focus;
    t_event_kind        kind;
    logic [BTN_W-1:0]   bit_sel;
    logic [1:0]         region;

    assign bit_sel = BTN_W'(1) << i_word.button_index;

    // Decode the command, form the candidate positions and button mask, then clamp and count.
    always_comb begin
        o_state        = i_state;
        o_pkt_we       = 1'b0;
        o_result_valid = 1'b1;
        upd_pos        = 1'b0;
        focus          = 1'b0;
        kind           = KIND_PACKET;
        cand_x         = '0;
        cand_y         = '0;
        unique case (i_word.action)
            ACT_BYTE: begin
                if (i_state.byte_index != PKT_LAST) begin
                    // First two bytes of a packet are only stored.
                    o_state.byte_index = i_state.byte_index + 2'd1;
                    o_pkt_we           = 1'b1;
                    o_result_valid     = 1'b0;
                end else begin
                    o_state.byte_index = '0;
                    o_state.buttons    = BTN_W'(i_pkt0 & PKT_BTN_MASK);
                    cand_x  = $signed({6'd0, i_state.pos_x})
                            + $signed({{10{i_pkt1[7]}}, i_pkt1});
                    cand_y  = $signed({6'd0, i_state.pos_y})
                            - $signed({{10{i_word.data_byte[7]}}, i_word.data_byte});
                    upd_pos = 1'b1;
                    focus   = i_pkt0[0];
                    kind    = KIND_PACKET;
                end
            end
            ACT_MOVE: begin
                cand_x  = $signed({6'd0, i_state.pos_x})
                        + $signed({{2{i_word.x_value[15]}}, i_word.x_value});
                cand_y  = $signed({6'd0, i_state.pos_y})
                        + $signed({{2{i_word.y_value[15]}}, i_word.y_value});
                upd_pos = 1'b1;
                kind    = KIND_MOVE;
            end
            ACT_SET: begin
                cand_x  = $signed({{2{i_word.x_value[15]}}, i_word.x_value});
                cand_y  = $signed({{2{i_word.y_value[15]}}, i_word.y_value});
                upd_pos = 1'b1;
                kind    = KIND_SET;
            end
            ACT_BUTTON: begin
                if (i_word.button_down) begin
                    o_state.buttons = i_state.buttons | bit_sel;
                    kind            = KIND_DOWN;
                end else begin
                    o_state.buttons = i_state.buttons & ~bit_sel;
                    kind            = KIND_UP;
                end
                focus = (i_word.button_index == 5'd0) && i_word.button_down;
            end
            default: begin
                o_result_valid = 1'b0;
            end
        endcase

        if (upd_pos) begin
            o_state.pos_x = clamp_coord(cand_x, i_cfg.max_x);
            o_state.pos_y = clamp_coord(cand_y, i_cfg.max_y);
        end
        if (o_result_valid) begin
            o_state.event_count = i_state.event_count + COUNT_W'(1);
        end
    end

    // Quadrant of the updated cursor.
    assign region = {o_state.pos_y >= i_cfg.split_y, o_state.pos_x >= i_cfg.split_x};

    always_comb begin
        o_result.event_kind    = kind;
        o_result.cursor_x      = o_state.pos_x;
        o_result.cursor_y      = o_state.pos_y;
        o_result.button_mask   = o_state.buttons;
        o_result.focus_request = focus;
        o_result.focus_region  = focus ? region : 2'd0;
        o_result.event_total   = o_state.event_count;
    end

endmodule

FILE: tb/sv/pmct_report_checker.sv
`timescale 1ns / 1ps

// Watches the command and report channels of the cursor tracker, keeps its own
// copy of the tracker state and limits, and compares every report word with the
// oldest predicted one.
module pmct_report_checker
    import pmct_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_in_word           i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_out_word          i_out_word,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [COORD_W-1:0] i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    // Limit registers as the tracker should hold them.
    logic [COORD_W-1:0] lim_x;
    logic [COORD_W-1:0] lim_y;
    logic [COORD_W-1:0] split_x;
    logic [COORD_W-1:0] split_y;

    // Predicted tracker state.
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [BTN_W-1:0]   held_buttons;
    logic [COUNT_W-1:0] events_seen;
    logic [1:0]         byte_slot;
    logic [7:0]         held_bytes [2];

    // Report words still owed by the tracker, oldest first.
    t_out_word reports_due [$];

    int mismatches      = 0;
    int reports_checked = 0;

    assign o_fail_count = mismatches;
    assign o_checked    = reports_checked;

    // Saturate a candidate coordinate at zero and at the register limit.
    function automatic logic [COORD_W-1:0] limit_coord(
        input int                 value,
        input logic [COORD_W-1:0] ceiling
    );
        logic [COORD_W-1:0] lim;
        lim = (ceiling < COORD_CAP) ? ceiling : COORD_CAP;
        if (value < 0) begin
            limit_coord = '0;
        end else if (value > int'(lim)) begin
            limit_coord = lim;
        end else begin
            limit_coord = value[COORD_W-1:0];
        end
    endfunction

    // Apply one command word to the predicted state. Returns 1 when the word
    // finishes an event, with the expected report in r.
    function automatic bit advance_cursor(input t_in_word w, output t_out_word r);
        bit               reported;
        bit               wants_focus;
        logic [BTN_W-1:0] bit_sel;
        reported    = 1'b1;
        wants_focus = 1'b0;
        r           = '0;
        case (w.action)
            ACT_BYTE: begin
                if (byte_slot < 2'd2) begin
                    // The first two bytes of a packet are only stored.
                    held_bytes[byte_slot[0]] = w.data_byte;
                    byte_slot                = byte_slot + 2'd1;
                    reported                 = 1'b0;
                end else begin
                    byte_slot    = '0;
                    held_buttons = BTN_W'(held_bytes[0] & PKT_BTN_MASK);
                    cur_x = limit_coord(int'(cur_x) + int'($signed(held_bytes[1])), lim_x);
                    cur_y = limit_coord(int'(cur_y) - int'($signed(w.data_byte)), lim_y);
                    wants_focus  = held_buttons[0];
                    r.event_kind = KIND_PACKET;
                end
            end
            ACT_MOVE: begin
                cur_x = limit_coord(int'(cur_x) + int'(w.x_value), lim_x);
                cur_y = limit_coord(int'(cur_y) + int'(w.y_value), lim_y);
                r.event_kind = KIND_MOVE;
            end
            ACT_SET: begin
                cur_x = limit_coord(int'(w.x_value), lim_x);
                cur_y = limit_coord(int'(w.y_value), lim_y);
                r.event_kind = KIND_SET;
            end
            ACT_BUTTON: begin
                // A single button touches only its own bit of the mask.
                bit_sel = BTN_W'(1) << w.button_index;
                if (w.button_down) begin
                    held_buttons = held_buttons | bit_sel;
                end else begin
                    held_buttons = held_buttons & ~bit_sel;
                end
                wants_focus  = (w.button_index == 5'd0) && w.button_down;
                r.event_kind = w.button_down ? KIND_DOWN : KIND_UP;
            end
        endcase
        if (reported) begin
            events_seen     = events_seen + COUNT_W'(1);
            r.cursor_x      = cur_x;
            r.cursor_y      = cur_y;
            r.button_mask   = held_buttons;
            r.focus_request = wants_focus;
            r.focus_region  = wants_focus ? {cur_y >= split_y, cur_x >= split_x} : 2'd0;
            r.event_total   = events_seen;
        end
        return reported;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $error("report %0d, %s: expected %0d, got %0d", reports_checked, field, want, got);
            mismatches++;
        end
    endtask

    // Track resets, register writes and both channels on every rising edge.
    always @(posedge i_clk) begin : track
        t_out_word predicted;
        if (!i_rst_n) begin
            lim_x        = MAX_X_RST;
            lim_y        = MAX_Y_RST;
            split_x      = SPLIT_X_RST;
            split_y      = SPLIT_Y_RST;
            cur_x        = POS_X_RST;
            cur_y        = POS_Y_RST;
            held_buttons = '0;
            events_seen  = '0;
            byte_slot    = '0;
            reports_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_X:   lim_x   = i_cfg_wdata;
                    CFG_MAX_Y:   lim_y   = i_cfg_wdata;
                    CFG_SPLIT_X: split_x = i_cfg_wdata;
                    CFG_SPLIT_Y: split_y = i_cfg_wdata;
                endcase
            end

            // A report taken now can only belong to an earlier command word.
            if (i_out_valid && i_out_ready) begin
                if (reports_due.size() == 0) begin
                    $error("report word arrived with no command waiting for one");
                    mismatches++;
                end else begin
                    predicted = reports_due.pop_front();
                    check_field("event_kind", predicted.event_kind, i_out_word.event_kind);
                    check_field("cursor_x", predicted.cursor_x, i_out_word.cursor_x);
                    check_field("cursor_y", predicted.cursor_y, i_out_word.cursor_y);
                    check_field("button_mask", predicted.button_mask, i_out_word.button_mask);
                    check_field("focus_request", predicted.focus_request,
                                i_out_word.focus_request);
                    check_field("focus_region", predicted.focus_region,
                                i_out_word.focus_region);
                    check_field("event_total", predicted.event_total, i_out_word.event_total);
                    reports_checked++;
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (advance_cursor(i_in_word, predicted)) begin
                    reports_due.push_back(predicted);
                end
            end
        end
        o_pending <= reports_due.size();
    end

endmodule

FILE: tb/sv/ps2_mouse_cursor_tracker_unit_test.sv
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker_unit_test;
    import pmct_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 50;
    localparam int SETTLE_CYCLES   = 4;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_word           in_word   = '0;
    logic               out_ready = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [COORD_W-1:0] cfg_wdata = '0;
    logic               in_ready;
    logic               out_valid;
    t_out_word          out_word;

    int fail_count;
    int pending;
    int checked;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int words_sent  = 0;
    int cycle_count = 0;

    ps2_mouse_cursor_tracker_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    pmct_report_checker report_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // The report side stalls at random, at the rate of the current phase.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Give up if the run hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_in_word make_word(input t_action act, input logic [7:0] data,
                                           input int x, input int y, input int idx,
                                           input bit down);
        t_in_word w;
        w.action       = act;
        w.data_byte    = data;
        w.x_value      = 16'(x);
        w.y_value      = 16'(y);
        w.button_index = 5'(idx);
        w.button_down  = down;
        return w;
    endfunction

    // Random command word of the given kind; unused fields carry noise too.
    function automatic t_in_word random_word(input t_action act);
        t_in_word w;
        w.action       = act;
        w.data_byte    = 8'($urandom);
        w.x_value      = 16'($urandom);
        w.y_value      = 16'($urandom);
        w.button_index = 5'($urandom);
        w.button_down  = 1'($urandom);
        case (act)
            ACT_MOVE: begin
                // Mostly small steps so the cursor wanders inside the limits.
                if ($urandom_range(9) < 7) begin
                    w.x_value = 16'(int'($urandom_range(128)) - 64);
                    w.y_value = 16'(int'($urandom_range(128)) - 64);
                end
            end
            ACT_SET: begin
                if ($urandom_range(9) < 6) begin
                    w.x_value = 16'($urandom_range(4200));
                    w.y_value = 16'($urandom_range(4200));
                end
            end
            ACT_BUTTON: begin
                if ($urandom_range(2) == 0) begin
                    w.button_index = '0;
                end
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    // Offer one word, with random idle cycles ahead of it, and wait until taken.
    task automatic push_word(input t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    // Drop valid, wait for every owed report, then let the pipeline drain.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_limits(input logic [COORD_W-1:0] mx, input logic [COORD_W-1:0] my,
                               input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_X;
        cfg_wdata <= mx;
        @(posedge clk);
        cfg_index <= CFG_MAX_Y;
        cfg_wdata <= my;
        @(posedge clk);
        cfg_index <= CFG_SPLIT_X;
        cfg_wdata <= sx;
        @(posedge clk);
        cfg_index <= CFG_SPLIT_Y;
        cfg_wdata <= sy;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        // Packet with all three buttons, the largest right step and a byte of -128.
        push_word(make_word(ACT_BYTE, 8'h07, 0, 0, 0, 0));
        push_word(make_word(ACT_BYTE, 8'h7F, 0, 0, 0, 0));
        push_word(make_word(ACT_BYTE, 8'h80, 0, 0, 0, 0));
        // High bits of the first byte must not reach the mask.
        push_word(make_word(ACT_BYTE, 8'hF8, 0, 0, 0, 0));
        push_word(make_word(ACT_BYTE, 8'h80, 0, 0, 0, 0));
        push_word(make_word(ACT_BYTE, 8'h7F, 0, 0, 0, 0));
        // Packet that holds button 0 and so asks for focus.
        push_word(make_word(ACT_BYTE, 8'hF9, 0, 0, 0, 0));
        push_word(make_word(ACT_BYTE, 8'h00, 0, 0, 0, 0));
        push_word(make_word(ACT_BYTE, 8'h00, 0, 0, 0, 0));
        // Moves that saturate at both ends.
        push_word(make_word(ACT_MOVE, 8'hFF, 32767, 32767, 31, 1));
        push_word(make_word(ACT_MOVE, 8'h00, -32768, -32768, 0, 0));
        // Position on the split lines, then just inside the upper left region.
        push_word(make_word(ACT_SET, 8'h00, 320, 250, 0, 0));
        push_word(make_word(ACT_BUTTON, 8'h00, 0, 0, 0, 1));
        push_word(make_word(ACT_SET, 8'h00, 319, 249, 0, 0));
        push_word(make_word(ACT_BUTTON, 8'h00, 0, 0, 0, 1));
        push_word(make_word(ACT_BUTTON, 8'h00, 0, 0, 0, 0));
        // Absolute positions out of range on either side.
        push_word(make_word(ACT_SET, 8'h00, 32767, -1, 0, 0));
        push_word(make_word(ACT_SET, 8'h00, -32768, 32767, 0, 0));
        // Top button, and releasing a button that is already up.
        push_word(make_word(ACT_BUTTON, 8'h00, 0, 0, 31, 1));
        push_word(make_word(ACT_BUTTON, 8'h00, 0, 0, 31, 0));
        push_word(make_word(ACT_BUTTON, 8'h00, 0, 0, 17, 0));
        // Packet with a move between its bytes.
        push_word(make_word(ACT_BYTE, 8'h01, 0, 0, 0, 0));
        push_word(make_word(ACT_MOVE, 8'h00, 5, -5, 0, 0));
        push_word(make_word(ACT_BYTE, 8'hFF, 0, 0, 0, 0));
        push_word(make_word(ACT_BYTE, 8'h01, 0, 0, 0, 0));
    endtask

    // Mostly whole packets and commands; now and then a packet is broken up.
    task automatic run_random(input int count);
        int done;
        int pick;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                push_word(random_word(ACT_BYTE));
                if ($urandom_range(9) == 0) begin
                    push_word(random_word(t_action'($urandom_range(1, 3))));
                end
                push_word(random_word(ACT_BYTE));
                push_word(random_word(ACT_BYTE));
                done += 3;
            end else if (pick < 55) begin
                push_word(random_word(ACT_MOVE));
                done++;
            end else if (pick < 75) begin
                push_word(random_word(ACT_SET));
                done++;
            end else begin
                push_word(random_word(ACT_BUTTON));
                done++;
            end
        end
    endtask

    initial begin : stimulus
        int p;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();

        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                case (p)
                    1: load_limits(12'd4095, 12'd4095, 12'd4095, 12'd4095);
                    2: load_limits(12'd0, 12'd0, 12'd0, 12'd0);
                    3: load_limits(MAX_X_RST, MAX_Y_RST, SPLIT_X_RST, SPLIT_Y_RST);
                    4: load_limits(12'd100, 12'd4095, 12'd0, 12'd4095);
                    5: load_limits(12'd4095, 12'd0, 12'd4095, 12'd0);
                    default: load_limits(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                                         12'($urandom_range(4095)), 12'($urandom_range(4095)));
                endcase
            end
            // Cycle through the idle patterns of both channels.
            case (p % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct = 54;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 54;
                end
                default: begin
                    idle_pct = 38;
                    stall_pct <= 38;
                end
            endcase
            run_random(WORDS_PER_PHASE);
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Sent %0d command words under %0d limit settings and four idle patterns;",
                 words_sent, PHASES);
        $display("compared %0d report words field by field.", checked);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
